[rtl/core/fmeg_pkg.sv]
package fmeg_pkg;

    // envelope stage codes
    localparam logic [2:0] ST_ATTACK       = 3'd0;
    localparam logic [2:0] ST_DECAY        = 3'd1;
    localparam logic [2:0] ST_SUSTAIN      = 3'd2;
    localparam logic [2:0] ST_SUSTAIN_HOLD = 3'd3;
    localparam logic [2:0] ST_RELEASE      = 3'd4;
    localparam logic [2:0] ST_RELEASE_HOLD = 3'd5;

    // request kinds
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_KEY_ON  = 2'd1;
    localparam logic [1:0] MODE_KEY_OFF = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ATTACK_RATE  = 3'd0;
    localparam logic [2:0] REG_DECAY_RATE   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN_RATE = 3'd2;
    localparam logic [2:0] REG_RELEASE_RATE = 3'd3;
    localparam logic [2:0] REG_DECAY_LIMIT  = 3'd4;

    localparam int RATE_W    = 21;
    localparam int MASK_W    = 13;
    localparam int ADD_W     = 8;
    localparam int LEVEL_W   = 11;
    localparam int FRAC_W    = 3;
    localparam int LIMIT_W   = 6;
    localparam int CNT_W     = 13;

    localparam logic [RATE_W-1:0]  RATE_RESET   = 21'd4097;
    localparam logic [LEVEL_W-1:0] SILENT_LEVEL = 11'd1024;
    localparam logic [6:0]         TOP_SEGMENT  = 7'd63;

    typedef struct packed {
        logic [RATE_W-1:0]  attack_rate;
        logic [RATE_W-1:0]  decay_rate;
        logic [RATE_W-1:0]  sustain_rate;
        logic [RATE_W-1:0]  release_rate;
        logic [LIMIT_W-1:0] decay_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         stage;
        logic [LEVEL_W-1:0] level;
        logic [FRAC_W-1:0]  frac;
    } t_env;

endpackage

[rtl/core/fmeg_cfg_regs.sv]
module fmeg_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [2:0]                  i_cfg_index,
    input  logic [fmeg_pkg::RATE_W-1:0] i_cfg_data,
    output fmeg_pkg::t_cfg              o_cfg
);

    fmeg_pkg::t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_rate  <= fmeg_pkg::RATE_RESET;
            r_cfg.decay_rate   <= fmeg_pkg::RATE_RESET;
            r_cfg.sustain_rate <= fmeg_pkg::RATE_RESET;
            r_cfg.release_rate <= fmeg_pkg::RATE_RESET;
            r_cfg.decay_limit  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fmeg_pkg::REG_ATTACK_RATE:  r_cfg.attack_rate  <= i_cfg_data;
                fmeg_pkg::REG_DECAY_RATE:   r_cfg.decay_rate   <= i_cfg_data;
                fmeg_pkg::REG_SUSTAIN_RATE: r_cfg.sustain_rate <= i_cfg_data;
                fmeg_pkg::REG_RELEASE_RATE: r_cfg.release_rate <= i_cfg_data;
                fmeg_pkg::REG_DECAY_LIMIT:
                    r_cfg.decay_limit <= i_cfg_data[fmeg_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/fmeg_step.sv]
module fmeg_step (
    input  fmeg_pkg::t_cfg             i_cfg,
    input  fmeg_pkg::t_env             i_env,
    input  logic [1:0]                 i_mode,
    input  logic [fmeg_pkg::CNT_W-1:0] i_counter,
    output fmeg_pkg::t_env             o_env,
    output logic                       o_changed
);

    logic [fmeg_pkg::RATE_W-1:0]  rate_word;
    logic                         active;
    logic [fmeg_pkg::MASK_W-1:0]  mask;
    logic [fmeg_pkg::ADD_W-1:0]   add;
    logic                         hit;
    logic [8:0]                   frac_sum;
    logic [5:0]                   step;
    logic [11:0]                  lvl_p1;
    logic [16:0]                  prod;
    logic [16:0]                  drop_full;
    logic [12:0]                  drop;
    logic [11:0]                  lin_sum;
    logic [fmeg_pkg::LEVEL_W-1:0] lin_lvl;
    logic [2:0]                   zero_stage;

    // rate word of the current stage; hold stages never step
    always_comb begin
        rate_word = fmeg_pkg::RATE_RESET;
        active    = 1'b1;
        unique case (i_env.stage)
            fmeg_pkg::ST_ATTACK:  rate_word = i_cfg.attack_rate;
            fmeg_pkg::ST_DECAY:   rate_word = i_cfg.decay_rate;
            fmeg_pkg::ST_SUSTAIN: rate_word = i_cfg.sustain_rate;
            fmeg_pkg::ST_RELEASE: rate_word = i_cfg.release_rate;
            default:              active    = 1'b0;
        endcase
    end

    // tick match and fractional step
    assign mask     = rate_word[fmeg_pkg::MASK_W-1:0];
    assign add      = rate_word[fmeg_pkg::RATE_W-1:fmeg_pkg::MASK_W];
    assign hit      = active && ((i_counter & mask) == (mask >> 1));
    assign frac_sum = {6'd0, i_env.frac} + {1'b0, add};
    assign step     = frac_sum[8:3];

    // attack: level - ceil((level+1)*step/16)
    assign lvl_p1    = {1'b0, i_env.level} + 12'd1;
    assign prod      = {5'd0, lvl_p1} * {11'd0, step};
    assign drop_full = prod + 17'd15;
    assign drop      = drop_full[16:4];

    // linear rise for decay, sustain and release
    assign lin_sum = {1'b0, i_env.level} + {6'd0, step};
    assign lin_lvl = lin_sum[fmeg_pkg::LEVEL_W-1:0];

    assign zero_stage = (i_cfg.decay_limit == '0) ? fmeg_pkg::ST_SUSTAIN
                                                  : fmeg_pkg::ST_DECAY;

    // next envelope state
    always_comb begin
        o_env     = i_env;
        o_changed = 1'b0;
        unique case (i_mode)
            fmeg_pkg::MODE_TICK: begin
                if (hit) begin
                    o_changed  = 1'b1;
                    o_env.frac = frac_sum[fmeg_pkg::FRAC_W-1:0];
                    if (i_env.stage == fmeg_pkg::ST_ATTACK) begin
                        if (drop >= {2'd0, i_env.level}) begin
                            o_env.level = '0;
                            o_env.stage = zero_stage;
                        end else begin
                            o_env.level = i_env.level - drop[fmeg_pkg::LEVEL_W-1:0];
                        end
                    end else begin
                        o_env.level = lin_lvl;
                        if ({3'd0, lin_lvl[10:4]} >= {3'd0, fmeg_pkg::TOP_SEGMENT}) begin
                            o_env.level = fmeg_pkg::SILENT_LEVEL;
                            o_env.stage = (i_env.stage == fmeg_pkg::ST_RELEASE)
                                        ? fmeg_pkg::ST_RELEASE_HOLD
                                        : fmeg_pkg::ST_SUSTAIN_HOLD;
                        end else if (i_env.stage == fmeg_pkg::ST_DECAY &&
                                     lin_lvl[10:4] == {1'b0, i_cfg.decay_limit}) begin
                            o_env.stage = fmeg_pkg::ST_SUSTAIN;
                        end
                    end
                end
            end
            fmeg_pkg::MODE_KEY_ON: begin
                if (i_env.stage >= fmeg_pkg::ST_RELEASE) begin
                    o_env.stage = (i_env.level == '0) ? zero_stage : fmeg_pkg::ST_ATTACK;
                end
            end
            fmeg_pkg::MODE_KEY_OFF: begin
                o_env.stage = fmeg_pkg::ST_RELEASE;
                if (i_env.level[10:4] >= fmeg_pkg::TOP_SEGMENT) begin
                    o_env.level = fmeg_pkg::SILENT_LEVEL;
                    o_env.stage = fmeg_pkg::ST_RELEASE_HOLD;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/fm_operator_envelope_generator_top.sv]
// pipeline: 2 register stages, the input register and then the result register; a request
// held in the input register moves into the result register once that register is free
// throughput: one request per cycle while m_axis_tready is high; the envelope state updates
// as the input register hands its request to the result register, so the next one sees it
// reset: synchronous active low; release hold at level 1024, step fraction 0,
// rate words 4097 and decay limit 0; input and output stages empty
module fm_operator_envelope_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [12:0] tick_counter, [15:13] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] stage, [13:3] level, [14] level_changed, [15] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    fmeg_pkg::t_cfg             cfg;
    fmeg_pkg::t_env             r_env;
    fmeg_pkg::t_env             n_env;
    logic                       n_changed;
    logic                       r_in_valid;
    logic [1:0]                 r_in_mode;
    logic [fmeg_pkg::CNT_W-1:0] r_in_counter;
    logic                       r_out_valid;
    logic [15:0]                r_out_data;
    logic                       advance;

    assign o_cfg_ready = 1'b1;

    fmeg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake: move input stage on when the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode    <= s_axis_tuser;
            r_in_counter <= s_axis_tdata[fmeg_pkg::CNT_W-1:0];
        end
    end

    fmeg_step u_step (
        .i_cfg     (cfg),
        .i_env     (r_env),
        .i_mode    (r_in_mode),
        .i_counter (r_in_counter),
        .o_env     (n_env),
        .o_changed (n_changed)
    );

    // envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env.stage <= fmeg_pkg::ST_RELEASE_HOLD;
            r_env.level <= fmeg_pkg::SILENT_LEVEL;
            r_env.frac  <= '0;
        end else if (advance) begin
            r_env <= n_env;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {1'b0, n_changed, n_env.level, n_env.stage};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
